// ----- hw/rtl/mqtt_payload_field_parser_defines.svh -----
// ----------------------------------------------------------------------------
// mqtt payload field parser assertion macros
// shared property forms for the port checker; clk and rst are taken from the
// scope where a macro is used
// ----------------------------------------------------------------------------
`ifndef MQTT_PAYLOAD_FIELD_PARSER_DEFINES_SVH
`define MQTT_PAYLOAD_FIELD_PARSER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define MPFP_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define MPFP_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/mpfp_pkg.sv -----
// ----------------------------------------------------------------------------
// mpfp_pkg
// field tags, status codes, flag masks and phase sequencing for the mqtt
// body field parser
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mpfp_pkg;

  typedef logic [4:0]  tag_t;
  typedef logic [1:0]  status_t;
  typedef logic [1:0]  kind_t;
  typedef logic [15:0] len_t;

  // field tags
  localparam tag_t TAG_NAME_LEN      = 5'd0;
  localparam tag_t TAG_NAME          = 5'd1;
  localparam tag_t TAG_PROTO_LEVEL   = 5'd2;
  localparam tag_t TAG_CONNECT_FLAGS = 5'd3;
  localparam tag_t TAG_KEEPALIVE     = 5'd4;
  localparam tag_t TAG_CLIENT_LEN    = 5'd5;
  localparam tag_t TAG_CLIENT        = 5'd6;
  localparam tag_t TAG_WTOPIC_LEN    = 5'd7;
  localparam tag_t TAG_WTOPIC        = 5'd8;
  localparam tag_t TAG_WMSG_LEN      = 5'd9;
  localparam tag_t TAG_WMSG          = 5'd10;
  localparam tag_t TAG_USER_LEN      = 5'd11;
  localparam tag_t TAG_USER          = 5'd12;
  localparam tag_t TAG_PASS_LEN      = 5'd13;
  localparam tag_t TAG_PASS          = 5'd14;
  localparam tag_t TAG_TOPIC_LEN     = 5'd15;
  localparam tag_t TAG_TOPIC         = 5'd16;
  localparam tag_t TAG_PACKET_ID     = 5'd17;
  localparam tag_t TAG_PAYLOAD       = 5'd18;
  localparam tag_t TAG_FILTER_LEN    = 5'd19;
  localparam tag_t TAG_FILTER        = 5'd20;
  localparam tag_t TAG_FILTER_QOS    = 5'd21;
  localparam tag_t TAG_IDLE          = 5'd22;

  // status codes
  localparam status_t ST_OK        = 2'd0;
  localparam status_t ST_SHORT     = 2'd1;
  localparam status_t ST_TRUNCATED = 2'd2;
  localparam status_t ST_BAD_QOS   = 2'd3;

  // packet kinds
  localparam kind_t KIND_CONNECT   = 2'd0;
  localparam kind_t KIND_PUBLISH   = 2'd1;
  localparam kind_t KIND_SUBSCRIBE = 2'd2;

  // connect flag and publish header masks
  localparam logic [7:0] WILL_BIT    = 8'h04;
  localparam logic [7:0] USER_BIT    = 8'h80;
  localparam logic [7:0] PASS_BIT    = 8'h40;
  localparam logic [3:0] DUP_BIT     = 4'h8;
  localparam logic [1:0] QOS_MASK    = 2'h3;
  localparam logic [3:0] RETAIN_BIT  = 4'h1;
  localparam logic [3:0] MIN_CONNECT = 4'd10;
  localparam logic [7:0] MAX_SUB_QOS = 8'd2;

  function automatic logic is_len_field(tag_t t);
    return (t == TAG_NAME_LEN) || (t == TAG_CLIENT_LEN) || (t == TAG_WTOPIC_LEN) ||
           (t == TAG_WMSG_LEN) || (t == TAG_USER_LEN) || (t == TAG_PASS_LEN) ||
           (t == TAG_TOPIC_LEN) || (t == TAG_FILTER_LEN);
  endfunction

  function automatic logic is_str_field(tag_t t);
    return (t == TAG_NAME) || (t == TAG_CLIENT) || (t == TAG_WTOPIC) ||
           (t == TAG_WMSG) || (t == TAG_USER) || (t == TAG_PASS) ||
           (t == TAG_TOPIC) || (t == TAG_FILTER);
  endfunction

  // field that follows a completed one; empty strings are skipped
  function automatic tag_t next_phase(tag_t t, kind_t kind, logic has,
                                      logic [7:0] cflags, logic [1:0] qos);
    tag_t after_user;
    tag_t after_will;
    tag_t after_client;
    tag_t after_topic;
    tag_t nxt;
    after_user   = ((cflags & PASS_BIT) != 8'h00) ? TAG_PASS_LEN : TAG_IDLE;
    after_will   = ((cflags & USER_BIT) != 8'h00) ? TAG_USER_LEN : after_user;
    after_client = ((cflags & WILL_BIT) != 8'h00) ? TAG_WTOPIC_LEN : after_will;
    after_topic  = (qos != 2'd0) ? TAG_PACKET_ID : TAG_PAYLOAD;
    case (t)
      TAG_NAME_LEN:      nxt = has ? TAG_NAME : TAG_PROTO_LEVEL;
      TAG_NAME:          nxt = TAG_PROTO_LEVEL;
      TAG_PROTO_LEVEL:   nxt = TAG_CONNECT_FLAGS;
      TAG_CONNECT_FLAGS: nxt = TAG_KEEPALIVE;
      TAG_KEEPALIVE:     nxt = TAG_CLIENT_LEN;
      TAG_CLIENT_LEN:    nxt = has ? TAG_CLIENT : after_client;
      TAG_CLIENT:        nxt = after_client;
      TAG_WTOPIC_LEN:    nxt = has ? TAG_WTOPIC : TAG_WMSG_LEN;
      TAG_WTOPIC:        nxt = TAG_WMSG_LEN;
      TAG_WMSG_LEN:      nxt = has ? TAG_WMSG : after_will;
      TAG_WMSG:          nxt = after_will;
      TAG_USER_LEN:      nxt = has ? TAG_USER : after_user;
      TAG_USER:          nxt = after_user;
      TAG_PASS_LEN:      nxt = has ? TAG_PASS : TAG_IDLE;
      TAG_TOPIC_LEN:     nxt = has ? TAG_TOPIC : after_topic;
      TAG_TOPIC:         nxt = after_topic;
      TAG_PACKET_ID:     nxt = (kind == KIND_SUBSCRIBE) ? TAG_FILTER_LEN : TAG_PAYLOAD;
      TAG_PAYLOAD:       nxt = TAG_PAYLOAD;
      TAG_FILTER_LEN:    nxt = has ? TAG_FILTER : TAG_FILTER_QOS;
      TAG_FILTER:        nxt = TAG_FILTER_QOS;
      TAG_FILTER_QOS:    nxt = TAG_FILTER_LEN;
      default:           nxt = TAG_IDLE;
    endcase
    return nxt;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/mqtt_payload_field_parser.sv -----
// ----------------------------------------------------------------------------
// mqtt_payload_field_parser
// tags each body byte of a connect, publish or subscribe packet with its field
//
// usage:
//   input channel (in_valid / in_stall) carries one body byte per transaction
//   with packet_kind, header_flags and first_byte / last_byte markers.
//   output channel (out_valid / out_stall) carries one tagged result per
//   input transaction, in order.
//   path: the input transaction loads the input register, and out_valid
//   rises from the result register once the byte moves on; the parse
//   state updates as a byte moves from the input register to the result one.
//   throughput: 1 byte per cycle while no result is stalled, set by the state
//   update loop on parse phase, field byte counter and field length.
//   stall: while out_stall holds a result, the input register keeps one
//   more byte and in_stall rises only once that register is also full.
//   reset: synchronous rst empties both registers and returns the parser to
//   the first connect field with all counters and flags cleared.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mqtt_payload_field_parser
  import mpfp_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  // input channel
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] data_byte,
  input  wire logic [1:0] packet_kind,
  input  wire logic [3:0] header_flags,
  input  wire logic       first_byte,
  input  wire logic       last_byte,
  // output channel
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [4:0]      field_tag,
  output logic [7:0]      byte_value,
  output logic            field_end,
  output logic            pub_dup,
  output logic [1:0]      pub_qos,
  output logic            pub_retain,
  output logic [1:0]      status,
  output logic            packet_done
);

  // input register
  logic       hold_valid;
  logic [7:0] hold_byte;
  kind_t      hold_kind;
  logic [3:0] hold_flags;
  logic       hold_first;
  logic       hold_last;

  // parse state
  tag_t       parse_phase;
  len_t       field_byte_count;
  len_t       field_length;
  logic [7:0] connect_flag_bits;
  logic [3:0] body_count_small;
  logic [1:0] held_qos;

  tag_t       parse_phase_next;
  len_t       field_byte_count_next;
  len_t       field_length_next;
  logic [7:0] connect_flag_bits_next;
  logic [3:0] body_count_small_next;
  logic [1:0] held_qos_next;

  // result of the byte in the input register
  tag_t       res_tag;
  logic       res_end;
  status_t    res_status;

  logic advance;
  logic in_accept;

  // handshake
  assign advance   = hold_valid && (!out_valid || !out_stall);
  assign in_stall  = hold_valid && !advance;
  assign in_accept = in_valid && !in_stall;

  // input register capture
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_accept) begin
      hold_valid <= 1'b1;
    end else if (advance) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      hold_byte  <= data_byte;
      hold_kind  <= packet_kind;
      hold_flags <= header_flags;
      hold_first <= first_byte;
      hold_last  <= last_byte;
    end
  end

  // field classification and next parse state
  always_comb begin
    tag_t       phase_e;
    len_t       count_e;
    len_t       len_e;
    logic [7:0] cflags_e;
    logic [3:0] body_e;
    logic [1:0] qos_e;
    len_t       cnt;
    logic       counted;
    logic       bad_qos;

    phase_e  = parse_phase;
    count_e  = field_byte_count;
    len_e    = field_length;
    cflags_e = connect_flag_bits;
    body_e   = body_count_small;
    qos_e    = held_qos;

    // first byte restarts at the opening field of the packet kind
    if (hold_first) begin
      case (hold_kind)
        KIND_CONNECT:   phase_e = TAG_NAME_LEN;
        KIND_PUBLISH:   phase_e = TAG_TOPIC_LEN;
        KIND_SUBSCRIBE: phase_e = TAG_PACKET_ID;
        default:        phase_e = TAG_IDLE;
      endcase
      count_e  = '0;
      len_e    = '0;
      cflags_e = '0;
      body_e   = '0;
      qos_e    = hold_flags[2:1] & QOS_MASK;
    end

    // saturating body counter
    body_count_small_next  = (body_e < MIN_CONNECT) ? body_e + 4'd1 : body_e;
    held_qos_next          = qos_e;
    connect_flag_bits_next = cflags_e;
    field_length_next      = len_e;

    res_tag = (phase_e > TAG_IDLE) ? TAG_IDLE : phase_e;
    cnt     = count_e + 16'd1;
    counted = 1'b1;
    bad_qos = 1'b0;
    res_end = 1'b0;

    if (is_len_field(res_tag)) begin
      // big-endian 16-bit length
      if (cnt == 16'd1) begin
        field_length_next = {hold_byte, 8'h00};
      end else begin
        field_length_next = len_e | {8'h00, hold_byte};
        res_end           = 1'b1;
      end
    end else if ((res_tag == TAG_KEEPALIVE) || (res_tag == TAG_PACKET_ID)) begin
      res_end = (cnt >= 16'd2);
    end else if ((res_tag == TAG_PROTO_LEVEL) || (res_tag == TAG_CONNECT_FLAGS) ||
                 (res_tag == TAG_FILTER_QOS)) begin
      res_end = 1'b1;
      if (res_tag == TAG_CONNECT_FLAGS) begin
        connect_flag_bits_next = hold_byte;
      end
      if ((res_tag == TAG_FILTER_QOS) && (hold_byte > MAX_SUB_QOS)) begin
        bad_qos = 1'b1;
      end
    end else if (is_str_field(res_tag)) begin
      res_end = (cnt >= len_e);
    end else begin
      // payload and trailing bytes are not counted
      counted = 1'b0;
      res_end = (res_tag == TAG_PAYLOAD) && hold_last;
    end

    // phase and counter advance
    parse_phase_next      = phase_e;
    field_byte_count_next = count_e;
    if (res_end) begin
      parse_phase_next      = next_phase(res_tag, hold_kind, field_length_next != 16'd0,
                                         connect_flag_bits_next, qos_e);
      field_byte_count_next = '0;
    end else if (counted) begin
      field_byte_count_next = cnt;
    end

    // status priority
    if (hold_last && (hold_kind == KIND_CONNECT) && (body_count_small_next < MIN_CONNECT)) begin
      res_status = ST_SHORT;
    end else if (hold_last && !res_end && counted) begin
      res_status = ST_TRUNCATED;
    end else if (bad_qos) begin
      res_status = ST_BAD_QOS;
    end else begin
      res_status = ST_OK;
    end

    // packet end returns to idle
    if (hold_last) begin
      parse_phase_next      = TAG_IDLE;
      field_byte_count_next = '0;
    end
  end

  // parse state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      parse_phase       <= TAG_NAME_LEN;
      field_byte_count  <= '0;
      field_length      <= '0;
      connect_flag_bits <= '0;
      body_count_small  <= '0;
      held_qos          <= '0;
    end else if (advance) begin
      parse_phase       <= parse_phase_next;
      field_byte_count  <= field_byte_count_next;
      field_length      <= field_length_next;
      connect_flag_bits <= connect_flag_bits_next;
      body_count_small  <= body_count_small_next;
      held_qos          <= held_qos_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      field_tag   <= res_tag;
      byte_value  <= hold_byte;
      field_end   <= res_end;
      pub_dup     <= (hold_kind == KIND_PUBLISH) && ((hold_flags & DUP_BIT) != 4'h0);
      pub_qos     <= (hold_kind == KIND_PUBLISH) ? held_qos_next : 2'd0;
      pub_retain  <= (hold_kind == KIND_PUBLISH) && ((hold_flags & RETAIN_BIT) != 4'h0);
      status      <= res_status;
      packet_done <= hold_last;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/mpfp_checker.sv -----
// ----------------------------------------------------------------------------
// mpfp_checker
// port-level checks on the mqtt body field parser, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "mqtt_payload_field_parser_defines.svh"

module mpfp_checker
  import mpfp_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_stall,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [4:0] field_tag,
  input wire logic       field_end,
  input wire logic [1:0] status
);

  // a stalled result holds
  `MPFP_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(field_tag) && $stable(status), "stalled result changed")

  // the input side only backs up behind a stalled result
  `MPFP_ASSERT_IMP(a_stall_cause, in_stall, out_valid && out_stall, "input stalled without output backpressure")

  // an accepted transaction while the output is free passes the input and result registers to out_valid
  `MPFP_ASSERT_NXT(a_no_loss, in_valid && !in_stall && !(out_valid && out_stall), ##1 out_valid, "accepted transaction did not reach output")

  // trailing bytes never complete a field
  `MPFP_ASSERT_IMP(a_idle_no_end, out_valid && (field_tag == TAG_IDLE), !field_end, "ignored byte marked as field end")

  // qos error only on a filter qos byte
  `MPFP_ASSERT_IMP(a_qos_tag, out_valid && (status == ST_BAD_QOS), field_tag == TAG_FILTER_QOS, "qos status on wrong field")

endmodule

bind mqtt_payload_field_parser mpfp_checker u_mpfp_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .field_tag (field_tag),
  .field_end (field_end),
  .status    (status)
);

`default_nettype wire
